>>> rtl/rtmp_message_chunker_core_defines.svh
// Assertion macros shared by the chunker RTL.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef RTMP_MESSAGE_CHUNKER_CORE_DEFINES_SVH
`define RTMP_MESSAGE_CHUNKER_CORE_DEFINES_SVH

`ifndef SYNTH
`define RMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMC_ASSERT(lbl, prop, msg)
`define RMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/rmc_pkg.sv
// Shared types and constants for the RTMP message chunker.
// No dependencies.
`timescale 1ns / 1ps

package rmc_pkg;

  localparam logic [7:0]  HDR_BASIC   = 8'h03;
  localparam logic [7:0]  HDR_CONT    = 8'hC3;
  localparam logic [15:0] CHUNK_RESET = 16'd128;
  localparam logic [3:0]  HDR_LAST    = 4'd11;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // what one accepted item turns into on the output side
  typedef enum logic [3:0] {
    JOB_HDR  = 4'b0001,  // 12-byte type-0 header
    JOB_PAY  = 4'b0010,  // one payload byte
    JOB_PAYC = 4'b0100,  // payload byte then continuation header
    JOB_ERR  = 4'b1000   // payload with no open message
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] timestamp;
    logic [23:0] msg_length;
    logic [7:0]  msg_type;
    logic [7:0]  data_byte;
  } job_t;

endpackage

>>> rtl/rmc_frame.sv
// Message framing state: chunk size register, byte and chunk counters.
// Turns each accepted beat into a job for the emitter. Uses rmc_pkg.
`timescale 1ns / 1ps

module rmc_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           accept,
  input  logic           action,
  input  logic [23:0]    timestamp,
  input  logic [23:0]    msg_length,
  input  logic [7:0]     msg_type,
  input  logic [7:0]     data_byte,
  output rmc_pkg::job_t  job
);

  logic [15:0] chunk_size_r;
  logic [23:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] chunk_pos_r, chunk_pos_nxt;
  logic        msg_open_r, msg_open_nxt;

  logic [15:0] limit;
  logic [23:0] bl_dec;
  logic [15:0] pos_inc;
  logic        cont;

  assign limit   = (chunk_size_r == 16'd0) ? 16'd1 : chunk_size_r;
  assign bl_dec  = bytes_left_r - 24'd1;
  assign pos_inc = chunk_pos_r + 16'd1;
  assign cont    = (pos_inc >= limit) && (bl_dec != 24'd0);

  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    chunk_pos_nxt    = chunk_pos_r;
    msg_open_nxt     = msg_open_r;
    job.timestamp    = timestamp;
    job.msg_length   = msg_length;
    job.msg_type     = msg_type;
    job.data_byte    = data_byte;
    job.kind         = rmc_pkg::JOB_HDR;
    if (action == rmc_pkg::ACT_START) begin
      job.kind       = rmc_pkg::JOB_HDR;
      bytes_left_nxt = msg_length;
      chunk_pos_nxt  = 16'd0;
      msg_open_nxt   = (msg_length != 24'd0);
    end else if (!msg_open_r) begin
      job.kind = rmc_pkg::JOB_ERR;
    end else begin
      job.kind       = cont ? rmc_pkg::JOB_PAYC : rmc_pkg::JOB_PAY;
      bytes_left_nxt = bl_dec;
      chunk_pos_nxt  = cont ? 16'd0 : pos_inc;
      if (bl_dec == 24'd0) begin
        msg_open_nxt  = 1'b0;
        chunk_pos_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= rmc_pkg::CHUNK_RESET;
      bytes_left_r <= '0;
      chunk_pos_r  <= '0;
      msg_open_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunk_size_r <= cfg_wr_data;
      end
      if (accept) begin
        bytes_left_r <= bytes_left_nxt;
        chunk_pos_r  <= chunk_pos_nxt;
        msg_open_r   <= msg_open_nxt;
      end
    end
  end

endmodule

>>> rtl/rmc_emit.sv
// Output serializer: holds one job and walks its bytes out one beat a cycle while out_stall is low.
// Can reload in the cycle its final beat leaves, or at once when empty. Uses rmc_pkg.
`timescale 1ns / 1ps

module rmc_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  rmc_pkg::job_t  job,
  output logic           busy_hold,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_error
);

  rmc_pkg::job_t job_r;
  logic          valid_r, valid_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic          beat_done;

  always_comb begin
    out_byte = 8'd0;
    out_last = 1'b1;
    unique case (job_r.kind)
      rmc_pkg::JOB_HDR: begin
        out_last = (idx_r == rmc_pkg::HDR_LAST);
        unique case (idx_r)
          4'd0:    out_byte = rmc_pkg::HDR_BASIC;
          4'd1:    out_byte = job_r.timestamp[23:16];
          4'd2:    out_byte = job_r.timestamp[15:8];
          4'd3:    out_byte = job_r.timestamp[7:0];
          4'd4:    out_byte = job_r.msg_length[23:16];
          4'd5:    out_byte = job_r.msg_length[15:8];
          4'd6:    out_byte = job_r.msg_length[7:0];
          4'd7:    out_byte = job_r.msg_type;
          default: out_byte = 8'd0;  // stream id bytes
        endcase
      end
      rmc_pkg::JOB_PAYC: begin
        out_last = (idx_r != 4'd0);
        out_byte = (idx_r == 4'd0) ? job_r.data_byte : rmc_pkg::HDR_CONT;
      end
      rmc_pkg::JOB_PAY: out_byte = job_r.data_byte;
      default:          out_byte = 8'd0;
    endcase
  end

  assign out_valid = valid_r;
  assign out_error = (job_r.kind == rmc_pkg::JOB_ERR);
  assign beat_done = valid_r && !out_stall;
  // free for a new job when empty or the final beat leaves now
  assign busy_hold = valid_r && !(beat_done && out_last);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 4'd0;
    end else if (beat_done) begin
      if (out_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

endmodule

>>> rtl/rtmp_message_chunker_core.sv
// Channel   Direction  Ports
// in        input      in_valid, in_stall, in_action .. in_data_byte
// out       output     out_valid, out_stall, out_byte, out_last, out_error
// cfg       input      cfg_wr_en, cfg_wr_data (chunk size)
//
// A start beat gives 12 output beats, a payload beat 1, or 2 when a 0xC3
// continuation follows; the one-byte output port sets this, one byte a cycle while out_stall is low.
// A new input beat is taken when the output is empty or in the cycle the previous item's final byte leaves.
// Synchronous active-low reset; chunk size resets to 128, counters to zero.
// Output stall holds the current byte; the input is stalled until the item's final byte leaves.
// Uses rmc_pkg, rmc_frame, rmc_emit and the shared defines header.
`timescale 1ns / 1ps
`include "rtmp_message_chunker_core_defines.svh"

module rtmp_message_chunker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [23:0] in_timestamp,
  input  logic [23:0] in_msg_length,
  input  logic [7:0]  in_msg_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error
);

  rmc_pkg::job_t job;
  logic          in_accept;
  logic          busy_hold;

  assign in_stall  = busy_hold;
  assign in_accept = in_valid && !busy_hold;

  rmc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_accept),
    .action      (in_action),
    .timestamp   (in_timestamp),
    .msg_length  (in_msg_length),
    .msg_type    (in_msg_type),
    .data_byte   (in_data_byte),
    .job         (job)
  );

  rmc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .job       (job),
    .busy_hold (busy_hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

  `RMC_ASSERT(a_err_single, !(out_valid && out_error) || (out_last && out_byte == 8'd0), "error beat must be a lone zero byte")
  `RMC_ASSERT(a_no_overrun, !in_accept || !out_valid || (!out_stall && out_last), "input taken while output item unfinished")
  `RMC_ASSERT_NEXT(a_accept_emits, in_accept, out_valid, "accepted beat produced no output")
  `RMC_ASSERT_NEXT(a_item_continues, out_valid && !out_stall && !out_last, out_valid, "item output cut short")

endmodule
